### hdl/dmaf_pkg.sv
package dmaf_pkg;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_PRELOAD = 2'd1,
    REQ_ACK     = 2'd2,
    REQ_RSVD    = 2'd3
  } req_t;

  typedef struct packed {
    logic changed;
    logic accepted;
  } flags_t;

  localparam int unsigned DEADBAND_RESET = 4;
  localparam int unsigned PCT_SCALE      = 100;
  localparam int unsigned PCT_W          = 7;

endpackage

### hdl/deadband_moving_average_filter_unit.sv
// Moving-average filter with deadband for converter samples.
// Input channel: in_valid/in_ready with in_req_type and in_sample. A sample
// request enters the ring only if it lies more than the deadband away from
// the current filtered value; a preload request fills the ring with the
// sample; an acknowledge request reports and clears the change flag.
// Result channel: out_valid/out_ready with out_filtered, out_percent,
// out_changed and out_accepted; every input word gives one result word.
// The user must write the deadband through cfg_we/cfg_deadband only while
// the unit is idle; the unit does not enforce this. One word is taken every
// cycle while the receiver takes results, as the ring, sum and filtered
// value update when a word moves from the input to the result register.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready then drops until the result is taken.
// Synchronous reset clears the ring, sum, filtered value and change flag,
// and sets the deadband to 4.
module deadband_moving_average_filter_unit #(
  parameter int WINDOW_LEN  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [SAMPLE_BITS-1:0]      cfg_deadband,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dmaf_pkg::req_t              in_req_type,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [SAMPLE_BITS-1:0]      out_filtered,
  output logic [dmaf_pkg::PCT_W-1:0]  out_percent,
  output logic                        out_changed,
  output logic                        out_accepted
);
  import dmaf_pkg::*;

  localparam int PW = SAMPLE_BITS + PCT_W;

  logic                   in_vld_r;
  req_t                   in_req_r;
  logic [SAMPLE_BITS-1:0] in_samp_r;
  logic                   out_vld_r;
  logic [SAMPLE_BITS-1:0] out_filt_r;
  flags_t                 out_flags_r;
  logic                   adv;
  logic [SAMPLE_BITS-1:0] core_filt;
  flags_t                 core_flags;
  logic [PW-1:0]          pct_prod;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  dmaf_core #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_deadband (cfg_deadband),
    .step         (adv),
    .req          (in_req_r),
    .sample       (in_samp_r),
    .filtered     (core_filt),
    .flags        (core_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r  <= in_req_type;
      in_samp_r <= in_sample;
    end
    if (adv) begin
      out_filt_r  <= core_filt;
      out_flags_r <= core_flags;
    end
  end

  assign pct_prod     = PW'(out_filt_r) * PW'(PCT_SCALE);
  assign out_valid    = out_vld_r;
  assign out_filtered = out_filt_r;
  assign out_percent  = pct_prod[SAMPLE_BITS +: PCT_W];
  assign out_changed  = out_flags_r.changed;
  assign out_accepted = out_flags_r.accepted;

endmodule

### hdl/dmaf_core.sv
module dmaf_core #(
  parameter int WINDOW_LEN  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [SAMPLE_BITS-1:0] cfg_deadband,
  input  logic                   step,
  input  dmaf_pkg::req_t         req,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] filtered,
  output dmaf_pkg::flags_t       flags
);
  import dmaf_pkg::*;

  localparam int IDXW  = $clog2(WINDOW_LEN);
  localparam int SUMW  = SAMPLE_BITS + IDXW;
  localparam int SHIFT = SUMW + IDXW;
  localparam int RW    = SUMW + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RW-1:0]          RECIP_C  = RW'(RECIP);
  localparam logic [IDXW-1:0]        IDX_LAST = IDXW'(WINDOW_LEN - 1);
  localparam logic [SAMPLE_BITS-1:0] DB_RST   = SAMPLE_BITS'(DEADBAND_RESET);

  logic [SAMPLE_BITS-1:0] ring_r   [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] ring_nxt [WINDOW_LEN];
  logic [SUMW-1:0]        sum_r, sum_nxt, sum_acc;
  logic [IDXW-1:0]        idx_r, idx_nxt;
  logic [SAMPLE_BITS-1:0] filt_r, filt_nxt;
  logic                   chg_r, chg_nxt;
  logic [SAMPLE_BITS-1:0] db_r;
  logic [SAMPLE_BITS:0]   s_x, f_x, db_x;
  logic                   take;
  logic [SUMW+RW-1:0]     quot_prod;

  assign s_x  = {1'b0, sample};
  assign f_x  = {1'b0, filt_r};
  assign db_x = {1'b0, db_r};
  assign take = (s_x > f_x + db_x) || (s_x + db_x < f_x);

  assign sum_acc   = sum_r - SUMW'(ring_r[idx_r]) + SUMW'(sample);
  assign quot_prod = (SUMW+RW)'(sum_acc) * (SUMW+RW)'(RECIP_C);

  always_comb begin
    ring_nxt = ring_r;
    sum_nxt  = sum_r;
    idx_nxt  = idx_r;
    filt_nxt = filt_r;
    chg_nxt  = chg_r;
    flags    = '{changed: chg_r, accepted: 1'b0};
    unique case (req)
      REQ_SAMPLE: begin
        if (take) begin
          ring_nxt[idx_r] = sample;
          sum_nxt         = sum_acc;
          idx_nxt         = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
          filt_nxt        = quot_prod[SHIFT +: SAMPLE_BITS];
          chg_nxt         = 1'b1;
          flags           = '{changed: 1'b1, accepted: 1'b1};
        end
      end
      REQ_PRELOAD: begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          ring_nxt[i] = sample;
        end
        sum_nxt  = SUMW'(sample) * SUMW'(WINDOW_LEN);
        filt_nxt = sample;
        chg_nxt  = 1'b0;
        flags    = '{changed: 1'b0, accepted: 1'b0};
      end
      REQ_ACK: begin
        chg_nxt = 1'b0;
      end
      REQ_RSVD: begin
      end
    endcase
  end

  assign filtered = filt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
      sum_r  <= '0;
      idx_r  <= '0;
      filt_r <= '0;
      chg_r  <= 1'b0;
      db_r   <= DB_RST;
    end else begin
      if (cfg_we) begin
        db_r <= cfg_deadband;
      end
      if (step) begin
        ring_r <= ring_nxt;
        sum_r  <= sum_nxt;
        idx_r  <= idx_nxt;
        filt_r <= filt_nxt;
        chg_r  <= chg_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(sum_r) && $stable(idx_r) && $stable(filt_r))
    else $error("filter state changed without a word");
  a_preload_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && req == REQ_PRELOAD |=> !chg_r && filt_r == $past(sample))
    else $error("preload did not set the filter");
  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && req == REQ_ACK |=> !chg_r && $stable(sum_r))
    else $error("acknowledge did not clear the change flag");
  a_accept_sets: assert property (@(posedge clk) disable iff (!rst_n)
    step && flags.accepted |=> chg_r && idx_r != $past(idx_r))
    else $error("accepted word did not advance the ring");
`endif

endmodule
